// File: design/sfss_pkg.sv
// ----------------------------------------------------------------------------
// sfss_pkg
// Shared widths, defaults and controller/datapath handshake structs for the
// shaft filter and Shell sort unit.
// ----------------------------------------------------------------------------
package sfss_pkg;

    localparam int DEF_MAX_SHAFTS = 32;
    localparam int DEF_POS_BITS   = 10;

    localparam int FLOOR_W     = 7;
    localparam int POS_FIELD_W = 10;
    localparam int SLOT_W      = 5;

    // s_tdata: query_floor, lowest_floor, highest_floor, shaft_pos
    localparam int IN_DATA_W  = 32;
    // m_tdata: slot_number, sorted_pos
    localparam int OUT_DATA_W = 16;

    typedef struct packed {
        logic load;       // item accepted
        logic load_last;  // accepted item closes the load
        logic gap_half;   // start a pass with half the gap
        logic outer_init; // left = end - gap
        logic end_inc;    // insertion step done, next end
        logic rd_pair;    // read left and right entries
        logic wr_left;    // first half of a swap
        logic wr_right;   // second half of a swap
        logic left_dec;   // left -= gap
        logic emit_rd;    // read entry at emit index
        logic emit_ld;    // move read entry into output register
        logic empty_ld;   // load the empty-run result
    } sfss_cmd_t;

    typedef struct packed {
        logic gap_done;    // halving the gap gives zero
        logic n_zero;      // nothing kept
        logic end_done;    // end reached the entry count
        logic no_swap;     // pair already in order
        logic left_lt_gap; // insertion reached the front
        logic emit_last;   // emit index is the last entry
        logic out_free;    // output register can take a result
    } sfss_status_t;

endpackage

// File: design/sfss_dpath.sv
// ----------------------------------------------------------------------------
// sfss_dpath
// Entry store, filter, sort counters, compare and output register.
// ----------------------------------------------------------------------------
module sfss_dpath #(
    parameter int MAX_SHAFTS = sfss_pkg::DEF_MAX_SHAFTS,
    parameter int POS_BITS   = sfss_pkg::DEF_POS_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sfss_pkg::sfss_cmd_t               cmd,
    output sfss_pkg::sfss_status_t            st,
    input  logic [sfss_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sfss_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import sfss_pkg::*;

    localparam int CNT_W = $clog2(MAX_SHAFTS + 1);
    localparam int IDX_W = (MAX_SHAFTS > 1) ? $clog2(MAX_SHAFTS) : 1;
    localparam int ENT_W = SLOT_W + POS_BITS;
    localparam int CMP_W = FLOOR_W + 1;

    logic [ENT_W-1:0] mem [MAX_SHAFTS];

    logic [CNT_W-1:0]  kept_count_reg, kept_count_next;
    logic [SLOT_W-1:0] arrival_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  gap_reg;
    logic [CNT_W-1:0]  end_reg;
    logic [IDX_W-1:0]  left_reg;
    logic [IDX_W-1:0]  emit_idx_reg;
    logic [ENT_W-1:0]  rd_a_reg;
    logic [ENT_W-1:0]  rd_b_reg;

    logic                   out_valid_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [POS_FIELD_W-1:0] out_pos_reg;
    logic                   out_none_reg;
    logic                   out_final_reg;

    logic [FLOOR_W-1:0]     q_floor, lo_floor, hi_floor;
    logic [POS_FIELD_W-1:0] in_pos;
    logic [CMP_W-1:0]       q_ext;
    logic                   pass;
    logic                   store_en;
    logic [CNT_W-1:0]       left_w;
    logic [CNT_W-1:0]       right_w;
    logic [IDX_W-1:0]       right_idx;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [ENT_W-1:0]       wr_data;
    logic [IDX_W-1:0]       rd_a_addr;

    assign q_floor  = s_tdata[FLOOR_W-1:0];
    assign lo_floor = s_tdata[2*FLOOR_W-1:FLOOR_W];
    assign hi_floor = s_tdata[3*FLOOR_W-1:2*FLOOR_W];
    assign in_pos   = s_tdata[3*FLOOR_W+POS_FIELD_W-1:3*FLOOR_W];
    assign q_ext    = {1'b0, q_floor};

    // query within bottom-1 .. top+1, done one wider so nothing wraps
    assign pass = s_tuser
               && (q_ext + CMP_W'(1) >= {1'b0, lo_floor})
               && (q_ext <= {1'b0, hi_floor} + CMP_W'(1));
    assign store_en = cmd.load && pass && (kept_count_reg < CNT_W'(MAX_SHAFTS));

    assign kept_count_next = store_en ? kept_count_reg + CNT_W'(1) : kept_count_reg;

    assign left_w    = CNT_W'(left_reg);
    assign right_w   = left_w + gap_reg;
    assign right_idx = right_w[IDX_W-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = kept_count_reg[IDX_W-1:0];
        wr_data = {arrival_reg, POS_BITS'(in_pos)};
        if (store_en)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.wr_left)
        begin
            wr_en   = 1'b1;
            wr_addr = left_reg;
            wr_data = rd_b_reg;
        end
        else if (cmd.wr_right)
        begin
            wr_en   = 1'b1;
            wr_addr = right_idx;
            wr_data = rd_a_reg;
        end
    end

    assign rd_a_addr = cmd.emit_rd ? emit_idx_reg : left_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_pair || cmd.emit_rd)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (cmd.rd_pair)
        begin
            rd_b_reg <= mem[right_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg <= '0;
            arrival_reg    <= '0;
            n_reg          <= '0;
            gap_reg        <= '0;
            end_reg        <= '0;
            left_reg       <= '0;
            emit_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (cmd.load_last)
                begin
                    kept_count_reg <= '0;
                    arrival_reg    <= '0;
                    n_reg          <= kept_count_next;
                    gap_reg        <= kept_count_next;
                    emit_idx_reg   <= '0;
                end
                else
                begin
                    kept_count_reg <= kept_count_next;
                    arrival_reg    <= arrival_reg + SLOT_W'(1);
                end
            end
            if (cmd.gap_half)
            begin
                gap_reg <= gap_reg >> 1;
                end_reg <= gap_reg >> 1;
            end
            if (cmd.outer_init)
            begin
                left_reg <= IDX_W'(end_reg - gap_reg);
            end
            if (cmd.end_inc)
            begin
                end_reg <= end_reg + CNT_W'(1);
            end
            if (cmd.left_dec)
            begin
                left_reg <= IDX_W'(left_w - gap_reg);
            end
            if (cmd.emit_ld && !st.emit_last)
            begin
                emit_idx_reg <= emit_idx_reg + IDX_W'(1);
            end
        end
    end

    // output register: holds a result while the next load streams in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ld || cmd.empty_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ld)
        begin
            out_slot_reg  <= rd_a_reg[ENT_W-1:POS_BITS];
            out_pos_reg   <= POS_FIELD_W'(rd_a_reg[POS_BITS-1:0]);
            out_none_reg  <= 1'b0;
            out_final_reg <= st.emit_last;
        end
        else if (cmd.empty_ld)
        begin
            out_slot_reg  <= '0;
            out_pos_reg   <= '0;
            out_none_reg  <= 1'b1;
            out_final_reg <= 1'b1;
        end
    end

    always_comb
    begin
        st.gap_done    = (gap_reg >> 1) == '0;
        st.n_zero      = (n_reg == '0);
        st.end_done    = (end_reg >= n_reg);
        st.no_swap     = rd_a_reg[POS_BITS-1:0] <= rd_b_reg[POS_BITS-1:0];
        st.left_lt_gap = left_w < gap_reg;
        st.emit_last   = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == n_reg;
        st.out_free    = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_pos_reg, out_slot_reg});
    assign m_tuser  = out_none_reg;
    assign m_tlast  = out_final_reg;

endmodule

// File: design/sfss_ctrl.sv
// ----------------------------------------------------------------------------
// sfss_ctrl
// Sequencer for load, Shell sort passes with compare-swap, and emit.
// ----------------------------------------------------------------------------
module sfss_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tlast,
    output logic                   s_tready,
    input  sfss_pkg::sfss_status_t st,
    output sfss_pkg::sfss_cmd_t    cmd
);
    import sfss_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_GAP,
        S_OUTER,
        S_READ,
        S_CMP,
        S_SWAP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMPTY
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load      = 1'b1;
                    cmd.load_last = s_tlast;
                    if (s_tlast)
                    begin
                        state_next = S_GAP;
                    end
                end
            end
            S_GAP:
            begin
                if (st.gap_done)
                begin
                    state_next = st.n_zero ? S_EMPTY : S_EMIT_RD;
                end
                else
                begin
                    cmd.gap_half = 1'b1;
                    state_next   = S_OUTER;
                end
            end
            S_OUTER:
            begin
                if (st.end_done)
                begin
                    state_next = S_GAP;
                end
                else
                begin
                    cmd.outer_init = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_pair = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (st.no_swap)
                begin
                    cmd.end_inc = 1'b1;
                    state_next  = S_OUTER;
                end
                else
                begin
                    cmd.wr_left = 1'b1;
                    state_next  = S_SWAP;
                end
            end
            S_SWAP:
            begin
                cmd.wr_right = 1'b1;
                if (st.left_lt_gap)
                begin
                    cmd.end_inc = 1'b1;
                    state_next  = S_OUTER;
                end
                else
                begin
                    cmd.left_dec = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (st.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    state_next  = st.emit_last ? S_LOAD : S_EMIT_RD;
                end
            end
            S_EMPTY:
            begin
                if (st.out_free)
                begin
                    cmd.empty_ld = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/shaft_filter_shell_sort_unit.sv
// Loading: one record item per cycle. After the last record the entries are
// Shell sorted through the single write port of the entry store; a pass halves
// the gap, an insertion start sets the left index, a compare reads the pair,
// a swap writes left then right. Results leave in order, held while stalled.
// The final result may still wait in the output register while the next load runs.
// Reset: asynchronous, active low; clears counters, controller and output valid.
// ----------------------------------------------------------------------------
// shaft_filter_shell_sort_unit
// Keeps shaft records that serve the query floor, sorts them by position and
// streams them out in order.
// ----------------------------------------------------------------------------
module shaft_filter_shell_sort_unit #(
    parameter int MAX_SHAFTS = sfss_pkg::DEF_MAX_SHAFTS,
    parameter int POS_BITS   = sfss_pkg::DEF_POS_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // query_floor[6:0], lowest_floor[13:7], highest_floor[20:14], shaft_pos[30:21]
    input  logic [sfss_pkg::IN_DATA_W-1:0]    s_tdata,
    // shaft_used
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // slot_number[4:0], sorted_pos[14:5]
    output logic [sfss_pkg::OUT_DATA_W-1:0]   m_tdata,
    // none_kept
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import sfss_pkg::*;

    sfss_cmd_t    cmd;
    sfss_status_t st;

    sfss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sfss_dpath #(
        .MAX_SHAFTS (MAX_SHAFTS),
        .POS_BITS   (POS_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // a swap always completes with its second write
    a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_left |=> cmd.wr_right)
        else $error("swap not completed");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_ld || cmd.empty_ld) |-> st.out_free)
        else $error("output register overwritten");

    // the empty-run result is the only and final one
    a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("empty result not final");

    // no record is taken while sorting or emitting
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_pair || cmd.wr_left || cmd.emit_rd) |-> !s_tready)
        else $error("input accepted during sort");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams shaft record loads into the filter/sort unit and checks each sorted
// result item against a behavioral filter plus halving-gap Shell sort. A short
// table covers the floor bounds, empty loads and position extremes; random loads
// follow, two of them long enough to fill the store and wrap the arrival index.
// ----------------------------------------------------------------------------
module testbench;
    import sfss_pkg::*;

    localparam int MAX_KEPT     = DEF_MAX_SHAFTS;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 100;
    localparam int N_ROWS       = 20;

    typedef struct packed {
        logic [FLOOR_W-1:0]     query;
        logic                   used;
        logic [FLOOR_W-1:0]     bottom;
        logic [FLOOR_W-1:0]     top;
        logic [POS_FIELD_W-1:0] pos;
        logic                   last;
    } shaft_rec_t;

    typedef struct packed {
        logic [SLOT_W-1:0]      slot;
        logic [POS_FIELD_W-1:0] pos;
        logic                   none;
        logic                   fin;
    } shaft_result_t;

    // typed = 1: the row closes a load with one obvious result, given in place
    typedef struct packed {
        shaft_rec_t    rec;
        logic          typed;
        shaft_result_t want;
    } shaft_row_t;

    localparam shaft_row_t DIRECTED_ROWS [N_ROWS] = '{
        // unused record alone: empty load
        '{'{7'd0,   1'b0, 7'd0,   7'd0,   10'd0,    1'b1}, 1'b1, '{5'd0, 10'd0,    1'b1, 1'b1}},
        '{'{7'd0,   1'b1, 7'd0,   7'd0,   10'd1023, 1'b1}, 1'b1, '{5'd0, 10'd1023, 1'b0, 1'b1}},
        '{'{7'd119, 1'b1, 7'd119, 7'd119, 10'd0,    1'b1}, 1'b1, '{5'd0, 10'd0,    1'b0, 1'b1}},
        // floor 60: edges of bottom-1 / top+1, unused, ties, inverted range
        '{'{7'd60,  1'b1, 7'd61,  7'd70,  10'd500,  1'b0}, 1'b0, '0},
        '{'{7'd60,  1'b1, 7'd62,  7'd70,  10'd400,  1'b0}, 1'b0, '0},
        '{'{7'd60,  1'b1, 7'd40,  7'd59,  10'd300,  1'b0}, 1'b0, '0},
        '{'{7'd60,  1'b1, 7'd40,  7'd58,  10'd200,  1'b0}, 1'b0, '0},
        '{'{7'd60,  1'b0, 7'd0,   7'd119, 10'd100,  1'b0}, 1'b0, '0},
        '{'{7'd60,  1'b1, 7'd0,   7'd119, 10'd300,  1'b0}, 1'b0, '0},
        '{'{7'd60,  1'b1, 7'd60,  7'd60,  10'd0,    1'b0}, 1'b0, '0},
        '{'{7'd60,  1'b1, 7'd119, 7'd0,   10'd700,  1'b0}, 1'b0, '0},
        '{'{7'd60,  1'b1, 7'd0,   7'd119, 10'd300,  1'b1}, 1'b0, '0},
        // floor 0: bottom of 0 or 1 both pass
        '{'{7'd0,   1'b1, 7'd1,   7'd5,   10'd1023, 1'b0}, 1'b0, '0},
        '{'{7'd0,   1'b1, 7'd2,   7'd5,   10'd5,    1'b0}, 1'b0, '0},
        '{'{7'd0,   1'b1, 7'd0,   7'd0,   10'd1023, 1'b0}, 1'b0, '0},
        '{'{7'd0,   1'b1, 7'd0,   7'd0,   10'd0,    1'b1}, 1'b0, '0},
        // nothing passes: empty load
        '{'{7'd119, 1'b1, 7'd0,   7'd117, 10'd10,   1'b0}, 1'b0, '0},
        '{'{7'd119, 1'b0, 7'd119, 7'd119, 10'd20,   1'b1}, 1'b1, '{5'd0, 10'd0,    1'b1, 1'b1}},
        // top floor
        '{'{7'd119, 1'b1, 7'd0,   7'd119, 10'd512,  1'b0}, 1'b0, '0},
        '{'{7'd119, 1'b1, 7'd119, 7'd119, 10'd511,  1'b1}, 1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    shaft_filter_shell_sort_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // shadow of the unit's entry store and counters
    logic [SLOT_W-1:0]      kept_slot [MAX_KEPT];
    logic [POS_FIELD_W-1:0] kept_pos  [MAX_KEPT];
    int                     kept_n = 0;
    logic [SLOT_W-1:0]      arrival_slot = '0;

    shaft_result_t sorted_shafts_q [$];
    shaft_result_t load_results_q [$];
    int            mismatch_count = 0;
    int            items_sent = 0;
    int            cycle_count = 0;
    int            burst_left = 1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Filter one record into the shadow store; on the closing record sort the
    // kept entries and queue them as this load's results.
    function automatic void filter_and_sort(input shaft_rec_t r);
        int n;
        int gap;
        int stop;
        int left;
        logic [SLOT_W-1:0]      ts;
        logic [POS_FIELD_W-1:0] tp;
        if (r.used && int'(r.query) >= int'(r.bottom) - 1 &&
            int'(r.query) <= int'(r.top) + 1 && kept_n < MAX_KEPT)
        begin
            kept_slot[kept_n] = arrival_slot;
            kept_pos[kept_n]  = r.pos;
            kept_n++;
        end
        arrival_slot = arrival_slot + 1'b1;
        if (!r.last)
            return;
        n = kept_n;
        kept_n = 0;
        arrival_slot = '0;
        if (n == 0)
        begin
            load_results_q.insert(load_results_q.size(),
                                  shaft_result_t'{'0, '0, 1'b1, 1'b1});
            return;
        end
        gap = n / 2;
        while (gap > 0)
        begin
            for (stop = gap; stop < n; stop++)
            begin
                left = stop - gap;
                // insertion walks back until a pair is already in order
                while (kept_pos[left] > kept_pos[left + gap])
                begin
                    ts = kept_slot[left];
                    tp = kept_pos[left];
                    kept_slot[left] = kept_slot[left + gap];
                    kept_pos[left]  = kept_pos[left + gap];
                    kept_slot[left + gap] = ts;
                    kept_pos[left + gap]  = tp;
                    if (left < gap)
                        break;
                    left -= gap;
                end
            end
            gap = gap / 2;
        end
        for (int k = 0; k < n; k++)
            load_results_q.insert(load_results_q.size(),
                shaft_result_t'{kept_slot[k], kept_pos[k], 1'b0, k == n - 1});
    endfunction

    task automatic send_shaft(input shaft_rec_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - 31){1'b0}}, r.pos, r.top, r.bottom, r.query};
        s_tuser  <= r.used;
        s_tlast  <= r.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        filter_and_sort(r);
    endtask

    // burst/gap pacing of the input side
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sorted_shafts_q.size() != 0)
            @(posedge clk);
    endtask

    // output stall pattern, reloaded now and then; all-ready stretches included
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_left = 0;

    always @(posedge clk)
    begin
        if (pattern_left == 0)
        begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom()) | 16'h0001);
            pattern_left  = $urandom_range(20, 200);
        end
        pattern_left--;
        m_tready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    always @(posedge clk)
    begin : result_check
        shaft_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sorted_shafts_q.size() == 0)
                report_mismatch($sformatf("result item with none expected, tdata %h", m_tdata));
            else
            begin
                want = sorted_shafts_q.pop_front();
                if (m_tdata[SLOT_W-1:0] !== want.slot)
                    report_mismatch($sformatf("slot_number %0d, expected %0d",
                                              m_tdata[SLOT_W-1:0], want.slot));
                if (m_tdata[SLOT_W+POS_FIELD_W-1:SLOT_W] !== want.pos)
                    report_mismatch($sformatf("sorted_pos %0d, expected %0d",
                                              m_tdata[SLOT_W+POS_FIELD_W-1:SLOT_W], want.pos));
                if (m_tuser !== want.none)
                    report_mismatch($sformatf("none_kept %b, expected %b", m_tuser, want.none));
                if (m_tlast !== want.fin)
                    report_mismatch($sformatf("final_entry %b, expected %b", m_tlast, want.fin));
            end
        end
    end

    initial
    begin
        shaft_row_t row;
        shaft_rec_t r;
        int         load_len;
        int         load_idx;
        int         floor_q;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            send_shaft(row.rec);
            if (row.typed)
            begin
                load_results_q.delete();
                sorted_shafts_q.insert(sorted_shafts_q.size(), row.want);
            end
            while (load_results_q.size() != 0)
                sorted_shafts_q.insert(sorted_shafts_q.size(), load_results_q.pop_front());
            pace_sender();
        end
        drain_results();

        load_idx = 0;
        while (items_sent < N_ROWS + RANDOM_ITEMS)
        begin
            // long loads fill the store and wrap the arrival index
            load_len = (load_idx == 2 || load_idx == 5) ? $urandom_range(33, 40)
                                                        : $urandom_range(1, 6);
            floor_q = $urandom_range(0, 119);
            for (int k = 0; k < load_len; k++)
            begin
                r.query = (load_len < 33 && $urandom_range(0, 9) == 0)
                          ? FLOOR_W'($urandom_range(0, 119)) : FLOOR_W'(floor_q);
                r.used  = (load_len >= 33) || ($urandom_range(0, 9) != 0);
                if (load_len >= 33 || $urandom_range(0, 3) != 0)
                begin
                    r.bottom = FLOOR_W'($urandom_range(0, (r.query < 119) ? r.query + 1 : 119));
                    r.top    = FLOOR_W'($urandom_range((r.query > 0) ? r.query - 1 : 0, 119));
                end
                else
                begin
                    r.bottom = FLOOR_W'($urandom_range(0, 119));
                    r.top    = FLOOR_W'($urandom_range(0, 119));
                end
                r.pos  = $urandom_range(0, 1) ? POS_FIELD_W'($urandom_range(0, 1023))
                                              : POS_FIELD_W'($urandom_range(0, 7));
                r.last = (k == load_len - 1);
                send_shaft(r);
                while (load_results_q.size() != 0)
                    sorted_shafts_q.insert(sorted_shafts_q.size(), load_results_q.pop_front());
                pace_sender();
            end
            if (load_idx == 3)
                drain_results();
            load_idx++;
        end

        s_tvalid <= 1'b0;
        while (sorted_shafts_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && sorted_shafts_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
